// ----- sv/tcc_pkg.sv -----
// Package for the text console engine: screen geometry, field widths,
// mode and command codes, and the word types carried between the modules.
// No dependencies.
package tcc_pkg;

    // Screen geometry.
    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths as seen on the ports.
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 4;

    // Internal widths: a cell address, and a sweep counter that can hold CELL_COUNT.
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes and tab step.
    localparam logic [CHAR_W-1:0] CHR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'd32;
    localparam int                TAB_STEP    = 4;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam int                CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    // Input word.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } in_item_t;

    // Result word.
    typedef struct packed {
        logic [CELL_W-1:0] cell_word;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } res_item_t;

    // Command classes decided by the front.
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_TAB,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    // Classified command word held in the queue.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

endpackage

// ----- sv/tcc_front.sv -----
// Front of the console engine: accepts input words and classifies them into commands.
// Depends on tcc_pkg; feeds tcc_cmd_queue.
module tcc_front
    import tcc_pkg::*;
(
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    input  logic     q_full,
    input  logic     init_busy,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic in_range;

    // Input is refused while the queue is full or the screen store is being cleared.
    assign full   = q_full | init_busy;
    assign q_push = push & ~full;

    // A read past the end of the store behaves exactly like an unused mode.
    assign in_range = (32'(item.cell_index) < CELL_COUNT);

    // Classify the word by mode and special characters.
    always_comb
    begin
        q_cmd.ch   = item.char_code;
        q_cmd.addr = ADDR_W'(item.cell_index);
        case (item.mode)
            MODE_PUT:
            begin
                if (item.char_code == CHR_TAB)
                    q_cmd.kind = CMD_TAB;
                else if (item.char_code == CHR_NEWLINE)
                    q_cmd.kind = CMD_NEWLINE;
                else
                    q_cmd.kind = CMD_PUT;
            end
            MODE_CLEAR: q_cmd.kind = CMD_CLEAR;
            MODE_READ:  q_cmd.kind = in_range ? CMD_READ : CMD_NOP;
            default:    q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ----- sv/tcc_cmd_queue.sv -----
// Short command queue that decouples the front from the back.
// Depends on tcc_pkg for the command word and queue depth.
module tcc_cmd_queue
    import tcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_valid
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_cmd  = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & q_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// ----- sv/tcc_back.sv -----
// Back of the console engine: cursor, color registers, screen store and the
// sweeps for reset clearing, screen clear and scroll; one result register.
// Depends on tcc_pkg; takes commands from tcc_cmd_queue.
module tcc_back
    import tcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data,
    output logic                 init_busy,
    output logic                 res_valid,
    output res_item_t            res,
    input  logic                 res_pop
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    // Control and cursor state.
    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [ADDR_W-1:0]  wr_cnt_reg,  wr_cnt_next;
    logic               rd_val_reg,  rd_val_next;
    logic               pend_reg,    pend_next;
    logic [CHAR_W-1:0]  pend_ch_reg, pend_ch_next;
    logic [ROW_W-1:0]   row_reg,     row_next;
    logic [COL_W-1:0]   col_reg,     col_next;
    logic [ADDR_W-1:0]  base_reg,    base_next;
    logic [COLOR_W-1:0] fg_reg,      fg_next;
    logic [COLOR_W-1:0] bg_reg,      bg_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg,     res_next;

    // Screen store with one write and one registered read port.
    logic [CELL_W-1:0]  mem [CELL_COUNT];
    logic [CELL_W-1:0]  rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               res_load;
    logic [COL_W-1:0]   res_col;
    logic               col_at_end;
    logic               last_row;
    logic [31:0]        tab_sum;

    function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch,
                                                    logic [COLOR_W-1:0] fg,
                                                    logic [COLOR_W-1:0] bg);
        return {bg, fg, ch};
    endfunction

    assign init_busy  = (state_reg == ST_INIT);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign col_at_end = (32'(col_reg) >= COLUMNS);
    assign last_row   = (32'(row_reg) + 1 >= ROWS);
    assign tab_sum    = 32'(col_reg) + TAB_STEP;

    // A command is taken only when the result register is free or being emptied.
    assign q_pop = (state_reg == ST_IDLE) && q_valid && (!res_valid_reg || res_pop);

    // Next-state logic for the command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        rd_val_next    = 1'b0;
        pend_next      = pend_reg;
        pend_ch_next   = pend_ch_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        res_load       = 1'b0;
        res_col        = col_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg[ADDR_W-1:0];

        // Configuration writes; indexes outside the list are ignored.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            // Clearing pass after reset: every cell becomes zero.
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_cmd.kind)
                        CMD_NOP:
                        begin
                            res_load = 1'b1;
                        end
                        CMD_TAB:
                        begin
                            col_next = (tab_sum > COLUMNS) ? COL_W'(COLUMNS)
                                                           : tab_sum[COL_W-1:0];
                            res_col  = col_next;
                            res_load = 1'b1;
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                pend_next   = 1'b0;
                                cnt_next    = CNT_W'(COLUMNS);
                                wr_cnt_next = '0;
                                state_next  = ST_SCROLL;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + ADDR_W'(COLUMNS);
                                res_col   = '0;
                                res_load  = 1'b1;
                            end
                        end
                        CMD_PUT:
                        begin
                            mem_wdata = make_cell(q_cmd.ch, fg_reg, bg_reg);
                            if (!col_at_end)
                            begin
                                // Plain write at the cursor.
                                mem_we    = 1'b1;
                                mem_waddr = base_reg + ADDR_W'(col_reg);
                                col_next  = col_reg + 1'b1;
                                res_col   = col_next;
                                res_load  = 1'b1;
                            end
                            else if (!last_row)
                            begin
                                // Wrap to the next row, then write at its first column.
                                mem_we    = 1'b1;
                                mem_waddr = base_reg + ADDR_W'(COLUMNS);
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + ADDR_W'(COLUMNS);
                                col_next  = COL_W'(1);
                                res_col   = col_next;
                                res_load  = 1'b1;
                            end
                            else
                            begin
                                // Wrap on the last row: scroll first, write afterwards.
                                pend_next    = 1'b1;
                                pend_ch_next = q_cmd.ch;
                                col_next     = '0;
                                cnt_next     = CNT_W'(COLUMNS);
                                wr_cnt_next  = '0;
                                state_next   = ST_SCROLL;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = q_cmd.addr;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            // Read data is in rdata_reg in the cycle after the request.
            ST_READ:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end

            // Scroll: read cell k, write it recolored at k minus one row.
            ST_SCROLL:
            begin
                if (cnt_reg != CNT_W'(CELL_COUNT))
                begin
                    mem_re      = 1'b1;
                    rd_val_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_val_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_cnt_reg;
                    mem_wdata   = make_cell(rdata_reg[CHAR_W-1:0], fg_reg, bg_reg);
                    wr_cnt_next = wr_cnt_reg + 1'b1;
                end
                else if (cnt_reg == CNT_W'(CELL_COUNT))
                begin
                    // Sweep done; place a character that was waiting on the wrap.
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = base_reg;
                        mem_wdata = make_cell(pend_ch_reg, fg_reg, bg_reg);
                        col_next  = COL_W'(1);
                    end
                    else
                    begin
                        col_next = '0;
                    end
                    pend_next  = 1'b0;
                    res_col    = col_next;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // Screen clear: spaces in the current colors, cursor home.
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = make_cell(CHR_SPACE, fg_reg, bg_reg);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    base_next  = '0;
                    res_col    = '0;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register: cell word only for reads, cursor after the step.
        if (res_load)
        begin
            res_next.cell_word  = (state_reg == ST_READ) ? rdata_reg : '0;
            res_next.cursor_row = row_next;
            res_next.cursor_col = res_col;
        end
        res_valid_next = (res_valid_reg && !res_pop) || res_load;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            wr_cnt_reg    <= '0;
            rd_val_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            pend_ch_reg   <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            fg_reg        <= COLOR_W'(15);
            bg_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            rd_val_reg    <= rd_val_next;
            pend_reg      <= pend_next;
            pend_ch_reg   <= pend_ch_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // Screen store ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

// ----- sv/text_console_cursor_scroll.sv -----
// Top level of the text console engine: front classifier, command queue, back engine.
// Depends on tcc_pkg, tcc_front, tcc_cmd_queue and tcc_back.
//
//  channel   handshake              word
//  -------   ---------------------  -------------------------------
//  input     push / full            item   (mode, char_code, cell_index)
//  result    pop / empty            result (cell_word, cursor_row, cursor_col)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Put and newline without scroll, tab and unused modes are done by the back engine in the cycle that takes them.
// A read goes through the registered read port of the screen store and then ST_READ.
// Scroll and clear sweep the store one cell per cycle through the single write port.
// After reset a clearing pass zeroes the store; full stays high while it runs.
// The two-word command queue keeps accepting input, until it is full, while a result waits to be popped.
module text_console_cursor_scroll
    import tcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output res_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_wr_cmd;
    logic q_pop;
    cmd_t q_rd_cmd;
    logic q_valid;
    logic init_busy;
    logic res_valid;

    assign cfg_ready = 1'b1;
    assign empty     = ~res_valid;

    // Input classification.
    tcc_front u_front (
        .push      (push),
        .full      (full),
        .item      (item),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    // Command queue.
    tcc_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_rd_cmd),
        .q_valid (q_valid)
    );

    // Execution engine.
    tcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_rd_cmd),
        .q_pop     (q_pop),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .init_busy (init_busy),
        .res_valid (res_valid),
        .res       (result),
        .res_pop   (pop & res_valid)
    );

endmodule

// ----- sv/tcc_checker.sv -----
// Port-level checker for the text console engine, bound to the top level.
// Depends on tcc_pkg and text_console_cursor_scroll.
module tcc_checker
    import tcc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input res_item_t result
);

    // A waiting result word holds until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed or vanished before pop");

    // The reported column never passes the end of the row.
    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(result.cursor_col) <= COLUMNS))
        else $error("cursor column past the row end");

    // The reported row stays on the screen.
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(result.cursor_row) < ROWS))
        else $error("cursor row past the last row");

    // Right after reset the clearing pass holds off input and no result waits.
    a_init: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (full && empty))
        else $error("input accepted or result shown during the clearing pass");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
